[src/pcl_pkg.sv]
package pcl_pkg;

  localparam int unsigned MaxLen = 4096;
  localparam int unsigned AddrW  = $clog2(MaxLen);
  localparam int unsigned CntW   = AddrW + 1;
  localparam int unsigned ScalarW = 21;
  localparam int unsigned PosW   = 12;
  localparam int unsigned UvalW  = 24;  // six hex digits of \u{...}

  localparam logic [ScalarW-1:0] ChLf = 21'h0A;
  localparam logic [ScalarW-1:0] ChDq = 21'h22;
  localparam logic [ScalarW-1:0] ChSq = 21'h27;
  localparam logic [ScalarW-1:0] ChBs = 21'h5C;
  localparam logic [ScalarW-1:0] ChLbrace = 21'h7B;
  localparam logic [ScalarW-1:0] ChRbrace = 21'h7D;

  typedef struct packed {
    logic [ScalarW-1:0] scalar;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            overflow;
  } out_item_t;

  // Scanner states
  typedef enum logic [3:0] {
    S_LOAD,   // collecting scalars
    S_TOP,    // outer walk, reading text at i
    S_STR,    // inside string body
    S_CHR1,   // first position of char literal
    S_CHRE,   // expecting closing apostrophe
    S_ESC1,   // character after backslash
    S_XH1,    // first hex digit of \x
    S_XH2,    // second hex digit of \x
    S_UBR,    // expecting { after \u
    S_UHEX,   // hex digits of \u{...}
    S_DONE    // result waits to be taken
  } state_e;

  function automatic logic is_hex(logic [ScalarW-1:0] c);
    return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h61 && c <= 21'h66) ||
           (c >= 21'h41 && c <= 21'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [ScalarW-1:0] c);
    logic [ScalarW-1:0] v;
    if (c <= 21'h39) v = c - 21'h30;
    else if (c >= 21'h61) v = c - 21'h57;
    else v = c - 21'h37;
    return v[3:0];
  endfunction

  function automatic logic prohibited(logic [ScalarW-1:0] c);
    logic cc;
    cc = (c <= 21'h1F) || (c >= 21'h7F && c <= 21'h9F);
    return cc && c != 21'h09 && c != 21'h0A && c != 21'h0C && c != 21'h0D;
  endfunction

endpackage

[src/pcl_ram.sv]
module pcl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/prohibited_char_outside_literal_scan.sv]
// Scan: after the item marked last, the buffered text is walked position by position,
//   each through a registered buffer read, with re-scans after a failed literal,
//   before the result item is offered.
// Throughput: one item per cycle while loading; no item is taken during the scan
//   or while the result waits. The single buffer read port sets the scan rate.
// Reset: asynchronous active low; clears fill count, overflow, found and read-valid flags and state.
module prohibited_char_outside_literal_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcl_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcl_pkg::out_item_t  out_item_o
);
  import pcl_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  top_q, top_d;     // opening position of current literal / walk index
  logic [CntW-1:0]  p_q, p_d;         // read pointer within literal
  logic             instr_q, instr_d; // escape belongs to a string (else char)
  logic [2:0]       dig_q, dig_d;
  logic [UvalW-1:0] val_q, val_d;
  logic             rd_q, rd_d;       // read data valid for p_q
  logic             found_q, found_d;
  logic [PosW-1:0]  pos_q, pos_d;

  logic             in_acc, we;
  logic [AddrW-1:0] raddr;
  logic [ScalarW-1:0] c;

  assign in_acc = in_valid_i && !in_stall_o;
  assign we     = in_acc && (fill_q < CntW'(MaxLen));

  pcl_ram #(.Width(ScalarW), .Depth(MaxLen)) u_buf (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(fill_q[AddrW-1:0]),
    .wdata_i(in_item_i.scalar),
    .raddr_i(raddr),
    .rdata_o(c)
  );

  assign raddr = p_q[AddrW-1:0];

  // Outputs of the handshake
  always_comb begin
    in_stall_o  = (state_q != S_LOAD);
    out_valid_o = (state_q == S_DONE);
    out_item_o.found    = found_q;
    out_item_o.position = pos_q;
    out_item_o.overflow = ovf_q;
  end

  // Next state and datapath
  always_comb begin
    logic fail, at_end;
    logic [CntW-1:0] nxt;
    state_d = state_q; fill_d = fill_q; ovf_d = ovf_q; top_d = top_q;
    p_d = p_q; instr_d = instr_q; dig_d = dig_q; val_d = val_q;
    rd_d = 1'b0; found_d = found_q; pos_d = pos_q;
    fail = 1'b0;
    at_end = (p_q >= fill_q);
    nxt = p_q + CntW'(1);
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (we) fill_d = fill_q + CntW'(1);
          else ovf_d = 1'b1;
          if (in_item_i.last) begin
            state_d = S_TOP; p_d = '0; found_d = 1'b0; pos_d = '0;
          end
        end
      end
      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_LOAD; fill_d = '0; ovf_d = 1'b0;
        end
      end
      default: begin
        if (at_end && state_q == S_TOP) begin
          state_d = S_DONE;
        end else if (at_end) begin
          fail = 1'b1;
        end else if (!rd_q) begin
          rd_d = 1'b1;  // wait for registered read of p_q
        end else begin
          unique case (state_q)
            S_TOP: begin
              top_d = p_q; p_d = nxt;
              if (c == ChDq) state_d = S_STR;
              else if (c == ChSq) state_d = S_CHR1;
              else if (prohibited(c)) begin
                found_d = 1'b1; pos_d = p_q[PosW-1:0]; state_d = S_DONE;
              end
            end
            S_STR: begin
              p_d = nxt;
              if (c == ChDq) state_d = S_TOP;
              else if (c == ChLf) fail = 1'b1;
              else if (c == ChBs) begin instr_d = 1'b1; state_d = S_ESC1; end
            end
            S_CHR1: begin
              p_d = nxt;
              if (c == ChLf || c == ChSq) fail = 1'b1;
              else if (c == ChBs) begin instr_d = 1'b0; state_d = S_ESC1; end
              else state_d = S_CHRE;
            end
            S_CHRE: begin
              p_d = nxt;
              if (c == ChSq) state_d = S_TOP;
              else fail = 1'b1;
            end
            S_ESC1: begin
              p_d = nxt;
              if (c == ChBs || c == ChDq || c == ChSq || c == 21'h6E ||
                  c == 21'h72 || c == 21'h74 || c == 21'h30)
                state_d = instr_q ? S_STR : S_CHRE;
              else if (c == 21'h78) state_d = S_XH1;
              else if (c == 21'h75) state_d = S_UBR;
              else fail = 1'b1;
            end
            S_XH1: begin
              p_d = nxt;
              if (is_hex(c)) state_d = S_XH2; else fail = 1'b1;
            end
            S_XH2: begin
              p_d = nxt;
              if (is_hex(c)) state_d = instr_q ? S_STR : S_CHRE;
              else fail = 1'b1;
            end
            S_UBR: begin
              p_d = nxt; dig_d = '0; val_d = '0;
              if (c == ChLbrace) state_d = S_UHEX; else fail = 1'b1;
            end
            S_UHEX: begin
              p_d = nxt;
              if (is_hex(c)) begin
                if (dig_q == 3'd6) fail = 1'b1;
                else begin
                  dig_d = dig_q + 3'd1;
                  val_d = {val_q[UvalW-5:0], hex_val(c)};
                end
              end else if (c == ChRbrace && dig_q != 3'd0 &&
                           val_q <= 24'h10FFFF &&
                           !(val_q >= 24'hD800 && val_q <= 24'hDFFF)) begin
                state_d = instr_q ? S_STR : S_CHRE;
              end else fail = 1'b1;
            end
            default: state_d = S_TOP;
          endcase
        end
        // Failed literal: treat the opening quote as plain text, resume after it
        if (fail) begin
          state_d = S_TOP; rd_d = 1'b0;
          p_d = top_q + CntW'(1);
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      rd_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      rd_q    <= rd_d;
      found_q <= found_d;
    end
  end

  // Scan payload registers
  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    p_q     <= p_d;
    instr_q <= instr_d;
    dig_q   <= dig_d;
    val_q   <= val_d;
    pos_q   <= pos_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MaxLen)) else $error("fill count beyond buffer");
  a_no_out_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("result offered while loading");
  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (fill_q == '0 && !ovf_q))
    else $error("state not cleared after result");
  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_q) |-> (pos_q == '0)) else $error("position without find");

endmodule

[bench/prohibited_char_outside_literal_scan_test.sv]
module prohibited_char_outside_literal_scan_test;
  import pcl_pkg::*;

  typedef logic [ScalarW-1:0] scalar_t;

  // Directed text runs: each row is one run with an optional typed-in answer
  typedef struct {
    scalar_t   text[$];
    bit        typed;
    out_item_t answer;
  } run_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_item_o;

  out_item_t scan_results_q[$];
  scalar_t   text_buf[MaxLen];
  int unsigned fill_cnt;
  bit        ovf_seen;
  int        n_fail;
  int        n_items;
  int        n_runs;
  int        n_found;
  int        n_ovf;
  bit        feed_done;

  prohibited_char_outside_literal_scan DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit hex_digit(scalar_t c);
    return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h61 && c <= 21'h66) ||
           (c >= 21'h41 && c <= 21'h46);
  endfunction

  function automatic bit banned_ctrl(scalar_t c);
    bit cc;
    cc = (c <= 21'h1F) || (c >= 21'h7F && c <= 21'h9F);
    return cc && c != 21'h09 && c != ChLf && c != 21'h0C && c != 21'h0D;
  endfunction

  // Escape at s; returns end index or 0
  function automatic int unsigned esc_end(int unsigned s, int unsigned n);
    scalar_t nx;
    int unsigned p;
    int unsigned digits;
    logic [31:0] val;
    if (s + 1 >= n || text_buf[s] != ChBs) return 0;
    nx = text_buf[s+1];
    if (nx == ChBs || nx == ChDq || nx == ChSq || nx == 21'h6E || nx == 21'h72 ||
        nx == 21'h74 || nx == 21'h30) return s + 2;
    if (nx == 21'h78) begin
      if (s + 3 >= n) return 0;
      if (!hex_digit(text_buf[s+2]) || !hex_digit(text_buf[s+3])) return 0;
      return s + 4;
    end
    if (nx == 21'h75) begin
      if (s + 2 >= n || text_buf[s+2] != ChLbrace) return 0;
      p = s + 3;
      val = 0;
      digits = 0;
      while (p < n && hex_digit(text_buf[p])) begin
        if (digits == 6) return 0;
        if (text_buf[p] <= 21'h39) val = (val << 4) | (text_buf[p] - 21'h30);
        else if (text_buf[p] >= 21'h61) val = (val << 4) | (text_buf[p] - 21'h57);
        else val = (val << 4) | (text_buf[p] - 21'h37);
        digits++;
        p++;
      end
      if (digits == 0) return 0;
      if (p >= n || text_buf[p] != ChRbrace) return 0;
      if (val > 32'h10FFFF || (val >= 32'hD800 && val <= 32'hDFFF)) return 0;
      return p + 1;
    end
    return 0;
  endfunction

  function automatic int unsigned string_end(int unsigned s, int unsigned n);
    int unsigned i;
    i = s + 1;
    while (i < n) begin
      if (text_buf[i] == ChDq) return i + 1;
      if (text_buf[i] == ChLf) return 0;
      if (text_buf[i] == ChBs) begin
        i = esc_end(i, n);
        if (i == 0) return 0;
      end else begin
        i++;
      end
    end
    return 0;
  endfunction

  function automatic int unsigned char_end(int unsigned s, int unsigned n);
    int unsigned i;
    i = s + 1;
    if (i >= n) return 0;
    if (text_buf[i] == ChLf) return 0;
    if (text_buf[i] == ChBs) begin
      i = esc_end(i, n);
      if (i == 0) return 0;
    end else begin
      if (text_buf[i] == ChSq) return 0;
      i++;
    end
    if (i >= n || text_buf[i] != ChSq) return 0;
    return i + 1;
  endfunction

  // Buffer one scalar; on the last one, scan and queue the answer
  function automatic void predict_scan(in_item_t it);
    int unsigned i;
    int unsigned e;
    out_item_t r;
    if (fill_cnt < MaxLen) begin
      text_buf[fill_cnt] = it.scalar;
      fill_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!it.last) return;
    r = '0;
    i = 0;
    while (i < fill_cnt) begin
      e = 0;
      if (text_buf[i] == ChDq) e = string_end(i, fill_cnt);
      else if (text_buf[i] == ChSq) e = char_end(i, fill_cnt);
      if (e != 0) begin
        i = e;
      end else if (banned_ctrl(text_buf[i])) begin
        r.found = 1'b1;
        r.position = i[PosW-1:0];
        break;
      end else begin
        i++;
      end
    end
    r.overflow = ovf_seen;
    scan_results_q = {scan_results_q, r};
    fill_cnt = 0;
    ovf_seen = 1'b0;
  endfunction

  // Send one item with a random hold-off; valid drops during a hold-off, else stays up
  task automatic send_item(scalar_t sc, bit lst);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{scalar: sc, last: lst};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_scan('{scalar: sc, last: lst});
    n_items++;
  endtask

  task automatic send_run(scalar_t txt[$]);
    foreach (txt[k]) send_item(txt[k], k == txt.size() - 1);
    n_runs++;
  endtask

  // Random scalar biased toward quotes, escapes, hex and controls
  function automatic scalar_t pick_scalar();
    scalar_t pool[$];
    pool = '{ChDq, ChSq, ChBs, ChLf, 21'h78, 21'h75, ChLbrace, ChRbrace,
             21'h6E, 21'h30, 21'h41, 21'h66, 21'h09, 21'h0C, 21'h0D};
    case ($urandom_range(0, 9))
      0, 1, 2: return pool[$urandom_range(0, pool.size() - 1)];
      3: return scalar_t'($urandom_range(0, 21'h1F));
      4: return scalar_t'($urandom_range(21'h7F, 21'h9F));
      5: return scalar_t'($urandom_range(0, 21'h1FFFFF));
      default: return scalar_t'($urandom_range(21'h20, 21'h7E));
    endcase
  endfunction

  // Well-formed literal with random content, sometimes corrupted
  function automatic void add_literal(ref scalar_t t[$]);
    int k;
    int nd;
    bit dq;
    dq = $urandom_range(0, 1);
    t = {t, (dq ? ChDq : ChSq)};
    for (k = 0; k < (dq ? $urandom_range(0, 5) : 1); k++) begin
      case ($urandom_range(0, 4))
        0: begin
          t = {t, ChBs};
          t = {t, ($urandom_range(0, 1) ? 21'h74 : ChSq)};
        end
        1: begin
          t = {t, ChBs}; t = {t, 21'h78};
          t = {t, 21'h37}; t = {t, 21'h46};
        end
        2: begin
          t = {t, ChBs}; t = {t, 21'h75}; t = {t, ChLbrace};
          nd = $urandom_range(1, 7);
          repeat (nd) t = {t, ($urandom_range(0, 1) ? 21'h44 : 21'h31)};
          t = {t, ChRbrace};
        end
        default: t = {t, ($urandom_range(0, 3) == 0 ? scalar_t'($urandom_range(0, 21'h9F))
                                                     : scalar_t'(21'h61))};
      endcase
    end
    if ($urandom_range(0, 7) != 0) t = {t, (dq ? ChDq : ChSq)};
  endfunction

  // Receive and check results; hold stall for a random wait before each item
  initial begin
    int rgap;
    out_item_t exp_r;
    out_stall_i = 1'b1;
    rgap = $urandom_range(0, 18);
    forever begin
      repeat (rgap) @(posedge clk_i);
      if (out_stall_i) out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (scan_results_q.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, out_item_o);
        n_fail++;
      end else begin
        exp_r = scan_results_q.pop_front();
        if (out_item_o.found !== exp_r.found || out_item_o.position !== exp_r.position ||
            out_item_o.overflow !== exp_r.overflow) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_item_o);
          n_fail++;
        end
        if (exp_r.found) n_found++;
        if (exp_r.overflow) n_ovf++;
      end
      rgap = $urandom_range(0, 18);
      if (rgap > 0) out_stall_i <= 1'b1;
    end
  end

  run_row_t dir_rows[$];

  initial begin
    run_row_t row;
    scalar_t t[$];
    int len;
    int waited;
    n_fail = 0; n_items = 0; n_runs = 0; n_found = 0; n_ovf = 0;
    fill_cnt = 0; ovf_seen = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    row.typed = 1; row.text = '{21'h00};        row.answer = '{1'b1, 12'd0, 1'b0};
    dir_rows = {dir_rows, row};
    row.text = '{21'h1FFFFF};                   row.answer = '{1'b0, 12'd0, 1'b0};
    dir_rows = {dir_rows, row};
    row.text = '{21'h41, 21'h09, ChLf, 21'h0C, 21'h0D, 21'h9F};
    row.answer = '{1'b1, 12'd5, 1'b0};
    dir_rows = {dir_rows, row};
    row.text = '{ChDq, 21'h01, ChDq, 21'h7F};   row.answer = '{1'b1, 12'd3, 1'b0};
    dir_rows = {dir_rows, row};
    row.text = '{ChSq, 21'h1F, ChSq, 21'hA0};   row.answer = '{1'b0, 12'd0, 1'b0};
    dir_rows = {dir_rows, row};
    row.typed = 0;
    row.text = '{ChDq, 21'h01, ChLf, ChDq};                         dir_rows = {dir_rows, row};
    row.text = '{ChDq, ChBs, 21'h78, 21'h61, 21'h46, 21'h02, ChDq}; dir_rows = {dir_rows, row};
    row.text = '{ChDq, ChBs, 21'h75, ChLbrace, 21'h31, 21'h30, 21'h46, 21'h46,
                 21'h46, 21'h46, ChRbrace, 21'h03, ChDq};            dir_rows = {dir_rows, row};
    row.text = '{ChDq, ChBs, 21'h75, ChLbrace, 21'h44, 21'h38, 21'h30, 21'h30,
                 ChRbrace, 21'h03, ChDq};                            dir_rows = {dir_rows, row};
    row.text = '{ChDq, ChBs, 21'h75, ChLbrace, 21'h30, 21'h30, 21'h30, 21'h30,
                 21'h30, 21'h30, 21'h30, ChRbrace, ChDq, 21'h04};    dir_rows = {dir_rows, row};
    row.text = '{ChDq, ChBs, 21'h75, ChLbrace, 21'h45, 21'h30, 21'h30, 21'h30,
                 21'h34, 21'h31, ChRbrace, ChDq, 21'h04};            dir_rows = {dir_rows, row};
    row.text = '{ChSq, ChBs, 21'h30, ChSq, 21'h05};                 dir_rows = {dir_rows, row};
    row.text = '{ChSq, ChSq, 21'h06, ChSq};                         dir_rows = {dir_rows, row};
    row.text = '{ChSq, 21'h07};                                     dir_rows = {dir_rows, row};
    row.text = '{ChDq, ChBs, 21'h71, 21'h08, ChDq, 21'h08};         dir_rows = {dir_rows, row};
    row.text = '{ChDq, ChBs};                                       dir_rows = {dir_rows, row};
    foreach (dir_rows[r]) begin
      send_run(dir_rows[r].text);
      if (dir_rows[r].typed && scan_results_q[$] != dir_rows[r].answer) begin
        $display("%0t: table row %0d expected %p predicted %p", $time, r,
                 dir_rows[r].answer, scan_results_q[$]);
        n_fail++;
      end
    end

    // Overflow: one full run past the buffer, position bits at the top
    t = {};
    repeat (MaxLen - 1) t = {t, 21'h61};
    t = {t, 21'h1B};
    t = {t, 21'h01};
    t = {t, 21'h02};
    send_run(t);

    // Random runs, mostly literal-laden well-formed text
    while (n_items < 1850 + MaxLen) begin
      t = {};
      len = $urandom_range(1, 12);
      while (t.size() < len) begin
        if ($urandom_range(0, 2) == 0) t = {t, pick_scalar()};
        else add_literal(t);
      end
      send_run(t);
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (scan_results_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items in %0d runs; %0d hits, %0d overflows; pending %0d.",
             n_items, n_runs, n_found, n_ovf, scan_results_q.size());
    if (n_fail == 0 && scan_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
